>>> hw/rtl/qrs_pkg.sv
// shared types and helpers for the quadratic root solver
// no dependencies; used by the cell modules and the top level
`default_nettype none
package qrs_pkg;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_LIN  = 2'd1,
		MODE_REAL = 2'd2,
		MODE_CPLX = 2'd3
	} mode_t;

	localparam int unsigned RAD_W  = 68;
	localparam int unsigned ROOT_W = 34;
	localparam int unsigned SREM_W = 37;
	localparam int unsigned NUM_W  = 50;
	localparam int unsigned DEN_W  = 33;
	localparam int unsigned DREM_W = 34;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} ctx_t;

	// one slot of the square root chain
	typedef struct packed {
		logic              vld;
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		ctx_t              ctx;
	} sq_t;

	// one slot of the divider chain, two numerators over one divisor
	typedef struct packed {
		logic              vld;
		mode_t             mode;
		logic [DEN_W-1:0]  d;
		logic              sd;
		logic [NUM_W-1:0]  nx;
		logic [NUM_W-1:0]  qx;
		logic [DREM_W-1:0] rx;
		logic              sx;
		logic [NUM_W-1:0]  ny;
		logic [NUM_W-1:0]  qy;
		logic [DREM_W-1:0] ry;
		logic              sy;
	} dv_t;

	// saturate a sign-magnitude quotient to Q16.16, msb of result is overflow
	function automatic logic [32:0] sat_q(input logic [NUM_W-1:0] m, input logic neg);
		logic [32:0] r;
		if (!neg && m > NUM_W'(32'h7FFF_FFFF)) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (neg && m > NUM_W'(33'h1_0000_0000 >> 1)) begin
			r = {1'b1, 32'h8000_0000};
		end else if (neg) begin
			r = {1'b0, 32'(~m + NUM_W'(1))};
		end else begin
			r = {1'b0, m[31:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/qrs_sqrt_cell.sv
// one bit of the floor square root, restoring digit recurrence
// depends on qrs_pkg
`default_nettype none
module qrs_sqrt_cell
	import qrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire sq_t  din,
	output sq_t       dout
);
	logic [SREM_W-1:0] rem_sh;
	logic [SREM_W-1:0] trial;
	logic              ge;

	logic              vld_q;
	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	ctx_t              ctx_q;

	assign rem_sh = {din.rem[SREM_W-3:0], din.rad[RAD_W-1 -: 2]};
	assign trial  = {1'b0, din.root, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {din.rad[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {din.root[ROOT_W-2:0], ge};
			ctx_q  <= din.ctx;
		end
	end

	assign dout = {vld_q, rad_q, rem_q, root_q, ctx_q};
endmodule
`default_nettype wire

>>> hw/rtl/qrs_div_cell.sv
// one quotient bit for both divider lanes, restoring long division
// depends on qrs_pkg
`default_nettype none
module qrs_div_cell
	import qrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire dv_t  din,
	output dv_t       dout
);
	logic [DREM_W-1:0] rx_sh, ry_sh, dd;
	logic              gx, gy;

	logic              vld_q;
	mode_t             mode_q;
	logic [DEN_W-1:0]  d_q;
	logic              sd_q;
	logic [NUM_W-1:0]  nx_q;
	logic [NUM_W-1:0]  qx_q;
	logic [DREM_W-1:0] rx_q;
	logic              sx_q;
	logic [NUM_W-1:0]  ny_q;
	logic [NUM_W-1:0]  qy_q;
	logic [DREM_W-1:0] ry_q;
	logic              sy_q;

	assign dd    = {1'b0, din.d};
	assign rx_sh = {din.rx[DREM_W-2:0], din.nx[NUM_W-1]};
	assign ry_sh = {din.ry[DREM_W-2:0], din.ny[NUM_W-1]};
	assign gx    = rx_sh >= dd;
	assign gy    = ry_sh >= dd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_q <= din.mode;
			d_q    <= din.d;
			sd_q   <= din.sd;
			sx_q   <= din.sx;
			sy_q   <= din.sy;
			nx_q   <= {din.nx[NUM_W-2:0], 1'b0};
			ny_q   <= {din.ny[NUM_W-2:0], 1'b0};
			rx_q   <= gx ? rx_sh - dd : rx_sh;
			ry_q   <= gy ? ry_sh - dd : ry_sh;
			qx_q   <= {din.qx[NUM_W-2:0], gx};
			qy_q   <= {din.qy[NUM_W-2:0], gy};
		end
	end

	assign dout = {vld_q, mode_q, d_q, sd_q, nx_q, qx_q, rx_q, sx_q, ny_q, qy_q, ry_q, sy_q};
endmodule
`default_nettype wire

>>> hw/rtl/quadratic_root_solver.sv
// quadratic root solver top level: discriminant front end, square root and divider chains
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
//
// channel  direction  fields (low bit first)
// s_*      in         tdata: coef_quad[31:0] coef_lin[63:32] coef_const[95:64]
// m_*      out        tdata: first_re, first_im, second_re, second_im (128 bits)
//                     tuser: has_roots, is_complex, overflow (3 bits)
//
// from input transaction to output the pipeline holds 3 front stages (register,
// multiply, discriminant), 34 square root cells, 1 numerator stage, 50 divider cells
// and the output register, which also takes the saturation
// one transaction per cycle is taken in steady state unless the output stalls; the chain is fully pipelined
// a stalled output freezes the whole chain, so s_tready follows m_tready combinationally
// reset clears only the valid bits of every stage
`default_nettype none
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // coef_quad, coef_lin, coef_const
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // first_re, first_im, second_re, second_im
	output logic [2:0]        m_tuser    // has_roots, is_complex, overflow
);
	localparam int unsigned SQ_N = ROOT_W;
	localparam int unsigned DV_N = NUM_W;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: capture coefficients
	logic               v_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_tdata[31:0];
			b_s1 <= s_tdata[63:32];
			c_s1 <= s_tdata[95:64];
		end
	end

	// stage 2: b squared and a times c
	logic [31:0]        bmag;
	logic               v_s2;
	logic [63:0]        bsq_s2;
	logic signed [63:0] ac_s2;
	logic signed [31:0] a_s2, b_s2, c_s2;

	assign bmag = b_s1[31] ? (~b_s1 + 32'd1) : b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s2 <= 64'(bmag) * 64'(bmag);
			ac_s2  <= 64'(a_s1) * 64'(c_s1);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
		end
	end

	// stage 3: discriminant magnitude and its sign, then into the root chain
	logic [63:0]       pmag;
	logic [65:0]       four_ac, b2w, dmag;
	logic              dneg;
	mode_t             mode_c;
	logic              vld_s3;
	logic [RAD_W-1:0]  rad_s3;
	ctx_t              ctx_s3;
	sq_t               sq [0:SQ_N];

	assign pmag    = ac_s2[63] ? 64'(-ac_s2) : 64'(ac_s2);
	assign four_ac = {pmag, 2'b00};
	assign b2w     = {2'b00, bsq_s2};

	always_comb begin
		dneg = 1'b0;
		if (ac_s2[63] || ac_s2 == 64'sd0) begin
			dmag = b2w + four_ac;
		end else if (b2w >= four_ac) begin
			dmag = b2w - four_ac;
		end else begin
			dmag = four_ac - b2w;
			dneg = 1'b1;
		end
		if (a_s2 == 32'sd0) begin
			mode_c = (b_s2 == 32'sd0) ? MODE_NONE : MODE_LIN;
		end else begin
			mode_c = dneg ? MODE_CPLX : MODE_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= {2'b00, dmag};
			ctx_s3 <= '{mode: mode_c, a: a_s2, b: b_s2, c: c_s2};
		end
	end

	// root and remainder start at zero
	assign sq[0] = {vld_s3, rad_s3, {SREM_W{1'b0}}, {ROOT_W{1'b0}}, ctx_s3};

	// floor square root, one result bit per cell
	for (genvar i = 0; i < SQ_N; i++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (sq[i]),
			.dout   (sq[i+1])
		);
	end

	// numerator stage: pick the two dividends and the divisor for the mode
	ctx_t               cx;
	logic signed [34:0] nbx, sxt, numx, numy;
	logic signed [32:0] den;
	logic [33:0]        mx, my;
	logic               vld_s38;
	mode_t              mode_s38;
	logic [DEN_W-1:0]   d_s38;
	logic               sd_s38;
	logic [NUM_W-1:0]   nx_s38, ny_s38;
	logic               sx_s38, sy_s38;
	dv_t                dv [0:DV_N];

	assign cx  = sq[SQ_N].ctx;
	assign nbx = -35'(cx.b);
	assign sxt = 35'(sq[SQ_N].root);

	always_comb begin
		case (cx.mode)
			MODE_REAL: begin
				numx = nbx + sxt;
				numy = nbx - sxt;
				den  = {cx.a, 1'b0};
			end
			MODE_CPLX: begin
				numx = nbx;
				numy = sxt;
				den  = {cx.a, 1'b0};
			end
			MODE_LIN: begin
				numx = -35'(cx.c);
				numy = -35'(cx.c);
				den  = 33'(cx.b);
			end
			default: begin
				numx = '0;
				numy = '0;
				den  = 33'sd1;
			end
		endcase
	end

	assign mx = numx[34] ? 34'(-numx) : 34'(numx);
	assign my = numy[34] ? 34'(-numy) : 34'(numy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s38 <= 1'b0;
		end else if (en) begin
			vld_s38 <= sq[SQ_N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s38 <= cx.mode;
			d_s38    <= den[32] ? 33'(-den) : 33'(den);
			sd_s38   <= den[32];
			nx_s38   <= {mx, 16'h0000};
			ny_s38   <= {my, 16'h0000};
			sx_s38   <= numx[34];
			sy_s38   <= numy[34];
		end
	end

	// quotients and remainders start at zero
	assign dv[0] = {vld_s38, mode_s38, d_s38, sd_s38,
		nx_s38, {NUM_W{1'b0}}, {DREM_W{1'b0}}, sx_s38,
		ny_s38, {NUM_W{1'b0}}, {DREM_W{1'b0}}, sy_s38};

	// truncating division, one quotient bit per cell for both lanes
	for (genvar j = 0; j < DV_N; j++) begin : g_dv
		qrs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (dv[j]),
			.dout   (dv[j+1])
		);
	end

	// saturation and packing
	dv_t         dl;
	logic [32:0] px, py, pyn;
	logic [31:0] r1, i1, r2, i2;
	logic        has, cplx, ovf;

	assign dl  = dv[DV_N];
	assign px  = sat_q(dl.qx, dl.sx ^ dl.sd);
	assign py  = sat_q(dl.qy, dl.sy ^ dl.sd);
	// conjugate imaginary part carries the opposite sign
	assign pyn = sat_q(dl.qy, !(dl.sy ^ dl.sd));

	always_comb begin
		r1 = '0; i1 = '0; r2 = '0; i2 = '0;
		has = 1'b1; cplx = 1'b0; ovf = 1'b0;
		case (dl.mode)
			MODE_NONE: begin
				has = 1'b0;
			end
			MODE_LIN: begin
				r1  = px[31:0];
				r2  = px[31:0];
				ovf = px[32];
			end
			MODE_REAL: begin
				r1  = px[31:0];
				r2  = py[31:0];
				ovf = px[32] | py[32];
			end
			MODE_CPLX: begin
				cplx = 1'b1;
				r1   = px[31:0];
				r2   = px[31:0];
				i1   = py[31:0];
				i2   = pyn[31:0];
				ovf  = px[32] | py[32] | pyn[32];
			end
			default: begin
				has = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {i2, r2, i1, r1};
			m_tuser <= {ovf, cplx, has};
		end
	end
endmodule
`default_nettype wire
